// ===== rtl/gsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS slow-data collector package
// Shared types, constants and helper functions of the collector.
// ----------------------------------------------------------------------------
package gsd_pkg;

   localparam int MAX_LINE_LENGTH = 256;
   localparam int LEN_W = $clog2(MAX_LINE_LENGTH);
   localparam int POS_W = (LEN_W > 8) ? LEN_W : 8;
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_SCRAMBLE_FIRST  = 3'd0;
   localparam logic [2:0] CSR_SCRAMBLE_SECOND = 3'd1;
   localparam logic [2:0] CSR_SCRAMBLE_THIRD  = 3'd2;
   localparam logic [2:0] CSR_TYPE_MASK       = 3'd3;
   localparam logic [2:0] CSR_GPS_TYPE_CODE   = 3'd4;

   // Input actions.
   localparam logic [1:0] ACT_DATA   = 2'd0;
   localparam logic [1:0] ACT_RESYNC = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // Stream identifiers.
   localparam logic [1:0] ST_POS    = 2'd0;
   localparam logic [1:0] ST_COURSE = 2'd1;
   localparam logic [1:0] ST_CRC    = 2'd2;
   localparam logic [1:0] ST_TEXT   = 2'd3;

   // Collection modes: stream identifier plus one, zero for none.
   localparam logic [2:0] MODE_NONE        = 3'd0;
   localparam logic [2:0] MODE_AFTER_POS   = 3'd2;
   localparam logic [2:0] MODE_AFTER_COURSE = 3'd4;

   // Line status codes.
   localparam logic [1:0] LS_CONT = 2'd0;
   localparam logic [1:0] LS_OK   = 2'd1;
   localparam logic [1:0] LS_BAD  = 2'd2;
   localparam logic [1:0] LS_OVF  = 2'd3;

   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   // Prefixes, byte 0 in the low lane.
   localparam logic [4:0][7:0] PFX_POS_C    = {8'h47, 8'h47, 8'h50, 8'h47, 8'h24};
   localparam logic [4:0][7:0] PFX_COURSE_C = {8'h4D, 8'h52, 8'h50, 8'h47, 8'h24};
   localparam logic [4:0][7:0] PFX_CRC_C    = {8'h43, 8'h52, 8'h43, 8'h24, 8'h24};

   typedef enum logic { CMD_CLEAR, CMD_BLOCK } cmd_op_type;
   typedef enum logic [1:0] { PFX_NONE, PFX_POS, PFX_COURSE, PFX_CRC } pfx_type;

   typedef struct packed {
      cmd_op_type       op;
      pfx_type          pfx;
      logic [4:0][7:0]  payload;
   } cmd_type;

   typedef struct packed {
      logic [1:0] stream_id;
      logic [7:0] byte_position;
      logic [7:0] stored_byte;
      logic       last;
      logic [1:0] line_status;
      logic       packet_ready;
      logic       position_valid;
      logic       course_valid;
      logic       text_valid;
      logic       crc_valid;
   } rsp_type;

   typedef enum logic { BK_IDLE, BK_BYTES } back_state_type;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
   endfunction

   // Reflected CRC-16 over one byte, least significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] ch);
      logic [15:0] c;
      logic [7:0]  d;
      logic        fb;
      c = crc;
      d = ch;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[0];
         c = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

// ===== rtl/gsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS slow-data collector front end
// Holds the configuration, descrambles and pairs halves, classifies blocks
// and queues commands for the back end.
// ----------------------------------------------------------------------------
module gsd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_slow_byte_a,
   input  logic [7:0]            req_slow_byte_b,
   input  logic [7:0]            req_slow_byte_c,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_data,
   output logic                  cmd_valid,
   input  logic                  cmd_pop,
   output gsd_pkg::cmd_type      cmd_data
);
   import gsd_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);

   logic [7:0]  scr_a_ff, scr_a_in, scr_b_ff, scr_b_in, scr_c_ff, scr_c_in;
   logic [7:0]  mask_ff, mask_in, code_ff, code_in;
   logic        pending_ff, pending_in;
   logic [23:0] first_ff, first_in;
   cmd_type     q_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic        accept, enq;
   cmd_type     enq_data;
   logic [7:0]  a, b, c;
   logic [4:0][7:0] blk;

   assign csr_ready = 1'b1;
   assign full      = (cnt_ff == (PTR_W+1)'(CMD_DEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ff];

   assign a = req_slow_byte_a ^ scr_a_ff;
   assign b = req_slow_byte_b ^ scr_b_ff;
   assign c = req_slow_byte_c ^ scr_c_ff;
   assign blk = {c, b, a, first_ff[7:0], first_ff[15:8]};

   always_comb begin
      scr_a_in = scr_a_ff;
      scr_b_in = scr_b_ff;
      scr_c_in = scr_c_ff;
      mask_in  = mask_ff;
      code_in  = code_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCRAMBLE_FIRST:  scr_a_in = csr_data;
            CSR_SCRAMBLE_SECOND: scr_b_in = csr_data;
            CSR_SCRAMBLE_THIRD:  scr_c_in = csr_data;
            CSR_TYPE_MASK:       mask_in  = csr_data;
            CSR_GPS_TYPE_CODE:   code_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pending_in = pending_ff;
      first_in   = first_ff;
      enq        = 1'b0;
      enq_data.op      = CMD_BLOCK;
      enq_data.pfx     = PFX_NONE;
      enq_data.payload = blk;
      if (blk == PFX_POS_C) begin
         enq_data.pfx = PFX_POS;
      end else if (blk == PFX_COURSE_C) begin
         enq_data.pfx = PFX_COURSE;
      end else if (blk == PFX_CRC_C) begin
         enq_data.pfx = PFX_CRC;
      end
      if (accept) begin
         unique case (req_action)
            ACT_DATA: begin
               if (!pending_ff) begin
                  first_in   = {a, b, c};
                  pending_in = 1'b1;
               end else begin
                  pending_in = 1'b0;
                  enq = ((first_ff[23:16] & mask_ff) == code_ff);
               end
            end
            ACT_RESYNC: pending_in = 1'b0;
            ACT_CLEAR: begin
               pending_in  = 1'b0;
               enq         = 1'b1;
               enq_data.op = CMD_CLEAR;
            end
            default: ;
         endcase
      end
      wr_in  = enq ? wr_ff + 1'b1 : wr_ff;
      rd_in  = cmd_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(enq) - (PTR_W+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_a_ff   <= 8'h70;
         scr_b_ff   <= 8'h4F;
         scr_c_ff   <= 8'h93;
         mask_ff    <= 8'hF0;
         code_ff    <= 8'h30;
         pending_ff <= 1'b0;
         first_ff   <= '0;
         wr_ff      <= '0;
         rd_ff      <= '0;
         cnt_ff     <= '0;
      end else begin
         scr_a_ff   <= scr_a_in;
         scr_b_ff   <= scr_b_in;
         scr_c_ff   <= scr_c_in;
         mask_ff    <= mask_in;
         code_ff    <= code_in;
         pending_ff <= pending_in;
         first_ff   <= first_in;
         wr_ff      <= wr_in;
         rd_ff      <= rd_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ff] <= enq_data;
      end
   end

endmodule

// ===== rtl/gsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS slow-data collector back end
// Selects the stream of each block and stores its payload one byte a cycle
// while the result queue has room, running the XOR and CRC-16 line checks.
// ----------------------------------------------------------------------------
module gsd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_pop,
   input  gsd_pkg::cmd_type      cmd_data,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output gsd_pkg::rsp_type      rsp_data
);
   import gsd_pkg::*;

   back_state_type   state_ff, state_in;
   logic [2:0]       idx_ff, idx_in;
   logic [1:0]       stream_ff, stream_in;
   logic [4:0][7:0]  bytes_ff, bytes_in;
   logic [2:0]       mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff [4];
   logic [LEN_W-1:0] len_in [4];
   logic [3:0]       vflags_ff, vflags_in;
   logic [7:0]       rx_ff, rx_in, xbs_ff, xbs_in;
   logic [LEN_W-1:0] star_ff, star_in;
   logic [15:0]      cas_ff, cas_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [15:0]      crc_ff, crc_in;
   logic [31:0]      hdr_ff, hdr_in;

   always_comb begin
      logic [1:0]       s;
      logic             start;
      logic             clr;
      logic [7:0]       raw, stored;
      logic [LEN_W-1:0] pos;
      logic [POS_W-1:0] pos_x;
      logic [LEN_W:0]   nxt;
      logic [1:0]       status;
      logic             ready;
      logic [15:0]      crc_n, sum;
      logic [31:0]      hdr_n;
      logic [15:0]      want;

      state_in  = state_ff;
      idx_in    = idx_ff;
      stream_in = stream_ff;
      bytes_in  = bytes_ff;
      mode_in   = mode_ff;
      len_in    = len_ff;
      vflags_in = vflags_ff;
      rx_in     = rx_ff;
      xbs_in    = xbs_ff;
      star_in   = star_ff;
      cas_in    = cas_ff;
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      hdr_in    = hdr_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      s      = ST_POS;
      start  = 1'b0;
      clr    = 1'b0;
      raw    = bytes_ff[idx_ff];
      stored = (stream_ff == ST_CRC) ? raw : {1'b0, raw[6:0]};
      pos    = len_ff[stream_ff];
      pos_x  = POS_W'(pos);
      nxt    = {1'b0, pos} + 1'b1;
      status = LS_CONT;
      ready  = 1'b0;
      crc_n  = crc_ff;
      hdr_n  = hdr_ff;
      sum    = ~crc_n;
      want   = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd_data.op == CMD_CLEAR) begin
                  mode_in   = MODE_NONE;
                  for (int i = 0; i < 4; i++) begin
                     len_in[i] = '0;
                  end
                  vflags_in = '0;
                  clr       = 1'b1;
               end else begin
                  start = 1'b1;
                  priority if (cmd_data.pfx == PFX_POS) begin
                     s = ST_POS;
                     len_in[ST_POS] = '0;
                     len_in[ST_COURSE] = '0;
                     len_in[ST_TEXT] = '0;
                     vflags_in[ST_POS] = 1'b0;
                     vflags_in[ST_COURSE] = 1'b0;
                     vflags_in[ST_TEXT] = 1'b0;
                     clr = 1'b1;
                  end else if (cmd_data.pfx == PFX_COURSE) begin
                     s = ST_COURSE;
                     len_in[ST_COURSE] = '0;
                     len_in[ST_TEXT] = '0;
                     vflags_in[ST_COURSE] = 1'b0;
                     vflags_in[ST_TEXT] = 1'b0;
                     clr = 1'b1;
                  end else if (cmd_data.pfx == PFX_CRC) begin
                     s = ST_CRC;
                     len_in[ST_CRC] = '0;
                     vflags_in[ST_CRC] = 1'b0;
                     clr = 1'b1;
                  end else if (mode_ff == MODE_AFTER_POS && len_ff[ST_COURSE] == '0) begin
                     s = ST_TEXT;
                     len_in[ST_TEXT] = '0;
                     vflags_in[ST_TEXT] = 1'b0;
                     clr = 1'b1;
                  end else if (mode_ff != MODE_NONE && mode_ff <= MODE_AFTER_COURSE) begin
                     s = 2'(mode_ff - 3'd1);
                  end else begin
                     start = 1'b0;
                  end
                  if (start) begin
                     mode_in   = {1'b0, s} + 3'd1;
                     stream_in = s;
                     bytes_in  = cmd_data.payload;
                     idx_in    = '0;
                     state_in  = BK_BYTES;
                  end
               end
            end
         end
         BK_BYTES: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (nxt >= (LEN_W+1)'(MAX_LINE_LENGTH)) begin
                  len_in[stream_ff]    = '0;
                  vflags_in[stream_ff] = 1'b0;
                  mode_in = MODE_NONE;
                  clr     = 1'b1;
                  status  = LS_OVF;
               end else begin
                  len_in[stream_ff] = nxt[LEN_W-1:0];
                  if (stream_ff == ST_CRC) begin
                     if (pos_x >= POS_W'(5) && pos_x <= POS_W'(8)) begin
                        hdr_n = {hdr_ff[23:0], raw};
                     end
                     if (pos_x >= POS_W'(10)) begin
                        crc_n = crc_byte(crc_ff, raw);
                     end
                     hdr_in = hdr_n;
                     crc_in = crc_n;
                     if (raw == CHAR_CR) begin
                        sum = ~crc_n;
                        mode_in = MODE_NONE;
                        clr = 1'b1;
                        if (pos_x >= POS_W'(10) && hdr_n == {hex_char(sum[15:12]),
                              hex_char(sum[11:8]), hex_char(sum[7:4]),
                              hex_char(sum[3:0])}) begin
                           vflags_in[ST_CRC] = 1'b1;
                           ready  = 1'b1;
                           status = LS_OK;
                        end else begin
                           len_in[ST_CRC]    = '0;
                           vflags_in[ST_CRC] = 1'b0;
                           status = LS_BAD;
                        end
                     end
                  end else if (raw == CHAR_LF) begin
                     want = {hex_char(xbs_ff[7:4]), hex_char(xbs_ff[3:0])};
                     if (stream_ff == ST_POS) begin
                        mode_in = MODE_AFTER_POS;
                     end else if (stream_ff == ST_COURSE) begin
                        mode_in = MODE_AFTER_COURSE;
                     end else begin
                        mode_in = MODE_NONE;
                     end
                     clr = 1'b1;
                     if (star_ff != '0 && cnt_ff == 2'd2 && cas_ff == want) begin
                        vflags_in[stream_ff] = 1'b1;
                        ready  = (stream_ff == ST_TEXT);
                        status = LS_OK;
                     end else begin
                        len_in[stream_ff]    = '0;
                        vflags_in[stream_ff] = 1'b0;
                        status = LS_BAD;
                     end
                  end else begin
                     if (star_ff != '0 && pos > star_ff && cnt_ff < 2'd2) begin
                        cas_in = {cas_ff[7:0], stored};
                        cnt_in = cnt_ff + 2'd1;
                     end
                     if (stored == CHAR_STAR &&
                         pos_x >= ((stream_ff == ST_TEXT) ? POS_W'(1) : POS_W'(2))) begin
                        xbs_in  = rx_ff;
                        star_in = pos;
                        cas_in  = '0;
                        cnt_in  = '0;
                     end
                     if (stream_ff == ST_TEXT || pos != '0) begin
                        rx_in = rx_ff ^ stored;
                     end
                  end
               end
               idx_in = idx_ff + 3'd1;
               if (status != LS_CONT || idx_ff == 3'd4) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase

      if (clr) begin
         rx_in   = '0;
         xbs_in  = '0;
         star_in = '0;
         cas_in  = '0;
         cnt_in  = '0;
         crc_in  = CRC_INIT;
         hdr_in  = '0;
      end

      rsp_data.stream_id      = stream_ff;
      rsp_data.byte_position  = pos_x[7:0];
      rsp_data.stored_byte    = stored;
      rsp_data.last           = (status != LS_CONT) || (idx_ff == 3'd4);
      rsp_data.line_status    = status;
      rsp_data.packet_ready   = ready;
      rsp_data.position_valid = vflags_in[ST_POS];
      rsp_data.course_valid   = vflags_in[ST_COURSE];
      rsp_data.text_valid     = vflags_in[ST_TEXT];
      rsp_data.crc_valid      = vflags_in[ST_CRC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         idx_ff    <= '0;
         stream_ff <= ST_POS;
         mode_ff   <= MODE_NONE;
         for (int i = 0; i < 4; i++) begin
            len_ff[i] <= '0;
         end
         vflags_ff <= '0;
         rx_ff     <= '0;
         xbs_ff    <= '0;
         star_ff   <= '0;
         cas_ff    <= '0;
         cnt_ff    <= '0;
         crc_ff    <= CRC_INIT;
         hdr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         stream_ff <= stream_in;
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         vflags_ff <= vflags_in;
         rx_ff     <= rx_in;
         xbs_ff    <= xbs_in;
         star_ff   <= star_in;
         cas_ff    <= cas_in;
         cnt_ff    <= cnt_in;
         crc_ff    <= crc_in;
         hdr_ff    <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

`ifndef NO_ASSERTIONS
   a_push_only_in_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (state_ff == BK_BYTES))
      else $error("result pushed outside byte phase");
   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.last) |=> (state_ff == BK_IDLE))
      else $error("sequencer did not return to idle after last byte");
   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_BYTES) |-> !cmd_pop)
      else $error("command taken while a block is in progress");
   a_at_most_five: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_BYTES) |-> (idx_ff <= 3'd4))
      else $error("byte index beyond block payload");
`endif

endmodule

// ===== rtl/gsd_rsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS slow-data collector result queue
// Small register queue that holds stored-byte results until they are popped.
// ----------------------------------------------------------------------------
module gsd_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_push,
   input  gsd_pkg::rsp_type      wr_data,
   output logic                  wr_full,
   input  logic                  pop,
   output logic                  empty,
   output gsd_pkg::rsp_type      rd_data
);
   import gsd_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);

   rsp_type          q_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             do_pop;

   assign wr_full = (cnt_ff == (PTR_W+1)'(RSP_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_pop  = pop && !empty;
   assign rd_data = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(wr_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_push) begin
         q_ff[wr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/gps_slow_data_sentence_collector_unit.sv =====
`timescale 1ns / 1ps
// Path: a second half-block passes through the command queue, the stream
// selection in the back end and the result queue before its first stored
// byte reaches the result ports; the back-end sequencer stores one byte a
// cycle while the result queue has room, and takes no new command until it
// is through with the current block.
// Reset: synchronous, active high; all streams empty, configuration at defaults.
// ----------------------------------------------------------------------------
// GPS slow-data sentence collector
// Descrambles slow-data half blocks, assembles GPS blocks and collects the
// position, course, CRC-packet and text streams with their line checks.
// ----------------------------------------------------------------------------
module gps_slow_data_sentence_collector_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_slow_byte_a,
   input  logic [7:0]  req_slow_byte_b,
   input  logic [7:0]  req_slow_byte_c,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_stream_id,
   output logic [7:0]  rsp_byte_position,
   output logic [7:0]  rsp_stored_byte,
   output logic        rsp_last,
   output logic [1:0]  rsp_line_status,
   output logic        rsp_packet_ready,
   output logic        rsp_position_valid,
   output logic        rsp_course_valid,
   output logic        rsp_text_valid,
   output logic        rsp_crc_valid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import gsd_pkg::*;

   // The front end accepts each input beat as it is pushed and only stalls
   // when its two-entry command queue is full. Each queued command is either a
   // clear of all streams or a GPS block tagged with its prefix match.
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   // The back end stores one byte a cycle into the result queue; it waits
   // whenever that queue is full, so a slow consumer never loses a beat.
   logic    rsp_push;
   logic    rsp_full;
   rsp_type rsp_wr;
   rsp_type rsp_rd;

   gsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_action      (req_action),
      .req_slow_byte_a (req_slow_byte_a),
      .req_slow_byte_b (req_slow_byte_b),
      .req_slow_byte_c (req_slow_byte_c),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd_data        (cmd_data)
   );

   gsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr)
   );

   gsd_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_push (rsp_push),
      .wr_data (rsp_wr),
      .wr_full (rsp_full),
      .pop     (pop),
      .empty   (empty),
      .rd_data (rsp_rd)
   );

   // The oldest result sits at the head of the queue and is shown as is.
   assign rsp_stream_id      = rsp_rd.stream_id;
   assign rsp_byte_position  = rsp_rd.byte_position;
   assign rsp_stored_byte    = rsp_rd.stored_byte;
   assign rsp_last           = rsp_rd.last;
   assign rsp_line_status    = rsp_rd.line_status;
   assign rsp_packet_ready   = rsp_rd.packet_ready;
   assign rsp_position_valid = rsp_rd.position_valid;
   assign rsp_course_valid   = rsp_rd.course_valid;
   assign rsp_text_valid     = rsp_rd.text_valid;
   assign rsp_crc_valid      = rsp_rd.crc_valid;

endmodule

// ===== bench/gps_slow_data_sentence_collector_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sentence collector checker
// Watches the input, result and register channels of the collector, keeps its
// own model of the stream state and compares every popped beat against the
// oldest predicted byte record.
// ----------------------------------------------------------------------------
module gps_slow_data_sentence_collector_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_slow_byte_a,
   input  logic [7:0]  req_slow_byte_b,
   input  logic [7:0]  req_slow_byte_c,
   input  logic        empty,
   input  logic        pop,
   input  logic [1:0]  rsp_stream_id,
   input  logic [7:0]  rsp_byte_position,
   input  logic [7:0]  rsp_stored_byte,
   input  logic        rsp_last,
   input  logic [1:0]  rsp_line_status,
   input  logic        rsp_packet_ready,
   input  logic        rsp_position_valid,
   input  logic        rsp_course_valid,
   input  logic        rsp_text_valid,
   input  logic        rsp_crc_valid,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          errors,
   output int          pending,
   output int          bytes_checked
);
   import gsd_pkg::*;

   rsp_type     stored_bytes_q[$];

   logic [7:0]  descr_a, descr_b, descr_c, mask_reg, code_reg;
   logic        half_waiting;
   logic [23:0] held_half;
   logic [2:0]  mode;
   int          line_len[4];
   logic [3:0]  held_valid;
   logic [7:0]  xor_sum, xor_at_star;
   int          star_at;
   logic [15:0] tail_chars;
   int          tail_count;
   logic [15:0] crc_acc;
   logic [31:0] crc_hdr;

   initial begin
      errors = 0;
      pending = 0;
      bytes_checked = 0;
   end

   function automatic logic [7:0] to_hex(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + n : 8'h41 + (n - 4'd10);
   endfunction

   task automatic restart_checks();
      xor_sum = '0;
      xor_at_star = '0;
      star_at = 0;
      tail_chars = '0;
      tail_count = 0;
      crc_acc = 16'hFFFF;
      crc_hdr = '0;
   endtask

   task automatic drop_line(input logic [1:0] s);
      line_len[s] = 0;
      held_valid[s] = 1'b0;
   endtask

   task automatic clear_streams();
      mode = MODE_NONE;
      for (int i = 0; i < 4; i++) line_len[i] = 0;
      held_valid = '0;
      half_waiting = 1'b0;
      restart_checks();
   endtask

   // Stores one payload byte into stream s and fills in the predicted record.
   task automatic store_byte(input logic [1:0] s, input logic [7:0] raw, output rsp_type r);
      logic [7:0]  val;
      logic [15:0] sum;
      logic [31:0] want_hdr;
      logic [15:0] want_tail;
      logic [7:0]  ch;
      logic        fb, ok;
      int          pos, xs;
      val = (s == ST_CRC) ? raw : {1'b0, raw[6:0]};
      pos = line_len[s];
      r = '0;
      r.stream_id = s;
      r.byte_position = pos[7:0];
      r.stored_byte = val;
      r.line_status = LS_CONT;
      if (pos + 1 >= MAX_LINE_LENGTH) begin
         drop_line(s);
         mode = MODE_NONE;
         restart_checks();
         r.line_status = LS_OVF;
      end else begin
         line_len[s] = pos + 1;
         if (s == ST_CRC) begin
            if (pos >= 5 && pos <= 8) crc_hdr = {crc_hdr[23:0], raw};
            if (pos >= 10) begin
               ch = raw;
               for (int i = 0; i < 8; i++) begin
                  fb = crc_acc[0] ^ ch[0];
                  crc_acc = crc_acc >> 1;
                  if (fb) crc_acc = crc_acc ^ 16'h8408;
                  ch = ch >> 1;
               end
            end
            if (raw == CHAR_CR) begin
               sum = ~crc_acc;
               want_hdr = {to_hex(sum[15:12]), to_hex(sum[11:8]),
                           to_hex(sum[7:4]), to_hex(sum[3:0])};
               ok = (pos >= 10) && (crc_hdr == want_hdr);
               mode = MODE_NONE;
               restart_checks();
               if (ok) begin
                  held_valid[ST_CRC] = 1'b1;
                  r.packet_ready = 1'b1;
                  r.line_status = LS_OK;
               end else begin
                  drop_line(ST_CRC);
                  r.line_status = LS_BAD;
               end
            end
         end else begin
            xs = (s == ST_TEXT) ? 0 : 1;
            if (raw == CHAR_LF) begin
               want_tail = {to_hex(xor_at_star[7:4]), to_hex(xor_at_star[3:0])};
               ok = (star_at != 0) && (tail_count == 2) && (tail_chars == want_tail);
               mode = (s == ST_POS) ? MODE_AFTER_POS :
                      (s == ST_COURSE) ? MODE_AFTER_COURSE : MODE_NONE;
               restart_checks();
               if (ok) begin
                  held_valid[s] = 1'b1;
                  r.packet_ready = (s == ST_TEXT);
                  r.line_status = LS_OK;
               end else begin
                  drop_line(s);
                  r.line_status = LS_BAD;
               end
            end else begin
               if (star_at != 0 && pos > star_at && tail_count < 2) begin
                  tail_chars = {tail_chars[7:0], val};
                  tail_count++;
               end
               if (val == CHAR_STAR && pos >= xs + 1) begin
                  xor_at_star = xor_sum;
                  star_at = pos;
                  tail_chars = '0;
                  tail_count = 0;
               end
               if (pos >= xs) xor_sum = xor_sum ^ val;
            end
         end
      end
      r.position_valid = held_valid[ST_POS];
      r.course_valid = held_valid[ST_COURSE];
      r.text_valid = held_valid[ST_TEXT];
      r.crc_valid = held_valid[ST_CRC];
   endtask

   task automatic take_item(input logic [1:0] act, input logic [7:0] a, b, c);
      logic [4:0][7:0] p;
      logic [7:0]      da, db, dc;
      logic [1:0]      s;
      logic            go;
      rsp_type         r;
      go = 1'b1;
      s = ST_POS;
      if (act == ACT_RESYNC) begin
         half_waiting = 1'b0;
      end else if (act == ACT_CLEAR) begin
         clear_streams();
      end else if (act == ACT_DATA) begin
         da = a ^ descr_a;
         db = b ^ descr_b;
         dc = c ^ descr_c;
         if (!half_waiting) begin
            held_half = {da, db, dc};
            half_waiting = 1'b1;
         end else begin
            half_waiting = 1'b0;
            p = {dc, db, da, held_half[7:0], held_half[15:8]};
            if ((held_half[23:16] & mask_reg) != code_reg) begin
               go = 1'b0;
            end else if (p == PFX_POS_C) begin
               s = ST_POS;
               drop_line(ST_POS);
               drop_line(ST_COURSE);
               drop_line(ST_TEXT);
               restart_checks();
            end else if (p == PFX_COURSE_C) begin
               s = ST_COURSE;
               drop_line(ST_COURSE);
               drop_line(ST_TEXT);
               restart_checks();
            end else if (p == PFX_CRC_C) begin
               s = ST_CRC;
               drop_line(ST_CRC);
               restart_checks();
            end else if (mode == MODE_AFTER_POS && line_len[ST_COURSE] == 0) begin
               s = ST_TEXT;
               drop_line(ST_TEXT);
               restart_checks();
            end else if (mode >= 3'd1 && mode <= 3'd4) begin
               s = 2'(mode - 3'd1);
            end else begin
               go = 1'b0;
            end
            if (go) begin
               mode = {1'b0, s} + 3'd1;
               for (int i = 0; i < 5; i++) begin
                  store_byte(s, p[i], r);
                  stored_bytes_q.push_back(r);
                  if (r.line_status != LS_CONT) break;
               end
               stored_bytes_q[$].last = 1'b1;
            end
         end
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_beat();
      rsp_type w;
      if (stored_bytes_q.size() == 0) begin
         $error("result beat with no prediction waiting (stream %0d, position %0d)",
                rsp_stream_id, rsp_byte_position);
         errors++;
      end else begin
         w = stored_bytes_q.pop_front();
         compare_field("stream_id", w.stream_id, rsp_stream_id);
         compare_field("byte_position", w.byte_position, rsp_byte_position);
         compare_field("stored_byte", w.stored_byte, rsp_stored_byte);
         compare_field("last", w.last, rsp_last);
         compare_field("line_status", w.line_status, rsp_line_status);
         compare_field("packet_ready", w.packet_ready, rsp_packet_ready);
         compare_field("position_valid", w.position_valid, rsp_position_valid);
         compare_field("course_valid", w.course_valid, rsp_course_valid);
         compare_field("text_valid", w.text_valid, rsp_text_valid);
         compare_field("crc_valid", w.crc_valid, rsp_crc_valid);
         bytes_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         descr_a = 8'h70;
         descr_b = 8'h4F;
         descr_c = 8'h93;
         mask_reg = 8'hF0;
         code_reg = 8'h30;
         held_half = '0;
         clear_streams();
         stored_bytes_q.delete();
      end else begin
         if (pop && !empty) check_beat();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCRAMBLE_FIRST:  descr_a = csr_data;
               CSR_SCRAMBLE_SECOND: descr_b = csr_data;
               CSR_SCRAMBLE_THIRD:  descr_c = csr_data;
               CSR_TYPE_MASK:       mask_reg = csr_data;
               CSR_GPS_TYPE_CODE:   code_reg = csr_data;
               default: ;
            endcase
         end
         if (push && !full) take_item(req_action, req_slow_byte_a, req_slow_byte_b,
                                      req_slow_byte_c);
      end
      pending = stored_bytes_q.size();
   end

endmodule

// ===== bench/gps_slow_data_sentence_collector_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sentence collector testbench
// Sends well-formed and damaged position, course, text and CRC lines, mixed
// with noise, through the collector under several scrambler and type settings,
// with random stalls on both queues; a checker module predicts every beat.
// ----------------------------------------------------------------------------
module gps_slow_data_sentence_collector_unit_test;
   import gsd_pkg::*;

   // Fault kinds used when a line is built.
   localparam int FAULT_NONE  = 0;
   localparam int FAULT_CHECK = 1;
   localparam int FAULT_SHORT = 2;
   localparam int FAULT_NOSTAR = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_action = ACT_DATA;
   logic [7:0]  req_slow_byte_a = '0;
   logic [7:0]  req_slow_byte_b = '0;
   logic [7:0]  req_slow_byte_c = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_stream_id;
   logic [7:0]  rsp_byte_position;
   logic [7:0]  rsp_stored_byte;
   logic        rsp_last;
   logic [1:0]  rsp_line_status;
   logic        rsp_packet_ready;
   logic        rsp_position_valid;
   logic        rsp_course_valid;
   logic        rsp_text_valid;
   logic        rsp_crc_valid;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   int          errors, pending, bytes_checked;
   int          items_sent = 0;
   int          lines_sent = 0;
   bit          stalls_on = 1'b1;
   int          pop_hold = 0;

   // The bench's view of the register file, used to scramble the stimulus.
   logic [7:0]  scr_a = 8'h70, scr_b = 8'h4F, scr_c = 8'h93;
   logic [7:0]  blk_mask = 8'hF0, blk_code = 8'h30;

   // Bytes of the lines being built, waiting to be cut into blocks.
   logic [7:0]  line_q[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gps_slow_data_sentence_collector_unit dut (.*);

   gps_slow_data_sentence_collector_unit_checker chk (
      .clock, .reset, .push, .full, .req_action, .req_slow_byte_a, .req_slow_byte_b,
      .req_slow_byte_c, .empty, .pop, .rsp_stream_id, .rsp_byte_position,
      .rsp_stored_byte, .rsp_last, .rsp_line_status, .rsp_packet_ready,
      .rsp_position_valid, .rsp_course_valid, .rsp_text_valid, .rsp_crc_valid,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .errors, .pending, .bytes_checked
   );

   // The result side pops freely, apart from random stall bursts.
   always @(posedge clock) begin
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         pop <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
         pop_hold <= $urandom_range(0, 18);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Sends one beat and returns at the edge where it was taken. An idle burst
   // may come first; push is only lowered inside that burst.
   task automatic send_item(input logic [1:0] act, input logic [7:0] a, b, c);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      push <= 1'b1;
      req_action <= act;
      req_slow_byte_a <= a;
      req_slow_byte_b <= b;
      req_slow_byte_c <= c;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   // Sends one six-byte block as two half-block beats, scrambled as the
   // collector expects. The type byte keeps random bits outside the mask.
   task automatic send_block(input logic [4:0][7:0] p);
      logic [7:0] t;
      t = (blk_code & blk_mask) | (8'($urandom) & ~blk_mask);
      send_item(ACT_DATA, t ^ scr_a, p[0] ^ scr_b, p[1] ^ scr_c);
      send_item(ACT_DATA, p[2] ^ scr_a, p[3] ^ scr_b, p[4] ^ scr_c);
   endtask

   // Cuts the pending line bytes into blocks, padding the last with noise.
   task automatic flush_line();
      logic [4:0][7:0] p;
      while (line_q.size() != 0) begin
         for (int i = 0; i < 5; i++)
            p[i] = (line_q.size() != 0) ? line_q.pop_front() : 8'($urandom);
         send_block(p);
      end
      lines_sent++;
   endtask

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + n : 8'h41 + (n - 4'd10);
   endfunction

   // Builds an NMEA-style line for the position, course or text stream. The
   // checksum covers the stored (seven-bit) characters, from byte one for the
   // sentences and from byte zero for text. Some characters go out with the
   // top bit set, which the collector strips.
   task automatic add_nmea(input logic [1:0] kind, input int fault, input int body_len);
      logic [7:0] sum, ch;
      int         first;
      first = line_q.size();
      if (kind == ST_POS) for (int i = 0; i < 5; i++) line_q.push_back(PFX_POS_C[i]);
      if (kind == ST_COURSE) for (int i = 0; i < 5; i++) line_q.push_back(PFX_COURSE_C[i]);
      for (int i = 0; i < body_len; i++) begin
         ch = 8'($urandom_range(32, 126));
         if (ch == CHAR_STAR && $urandom_range(0, 3) != 0) ch = 8'h2B;
         if (ch != CHAR_STAR && $urandom_range(0, 7) == 0) ch[7] = 1'b1;
         line_q.push_back(ch);
      end
      sum = '0;
      for (int i = first + ((kind == ST_TEXT) ? 0 : 1); i < line_q.size(); i++)
         sum = sum ^ {1'b0, line_q[i][6:0]};
      if (fault != FAULT_NOSTAR) line_q.push_back(CHAR_STAR);
      line_q.push_back(hex_digit(sum[7:4]) ^ ((fault == FAULT_CHECK) ? 8'h01 : 8'h00));
      if (fault != FAULT_SHORT) line_q.push_back(hex_digit(sum[3:0]));
      line_q.push_back(CHAR_LF);
   endtask

   // Builds a CRC packet: header, four hex characters of the inverted CRC,
   // a separator, raw data bytes and CR. The CRC runs over the data and CR.
   task automatic add_crc_packet(input int fault, input int data_len);
      logic [7:0]  d[$];
      logic [15:0] crc;
      logic [7:0]  ch;
      logic        fb;
      for (int i = 0; i < 5; i++) line_q.push_back(PFX_CRC_C[i]);
      if (fault == FAULT_SHORT) begin
         repeat ($urandom_range(0, 4)) line_q.push_back(hex_digit(4'($urandom)));
         line_q.push_back(CHAR_CR);
      end else begin
         for (int i = 0; i < data_len; i++) begin
            ch = 8'($urandom);
            d.push_back((ch == CHAR_CR) ? 8'h8D : ch);
         end
         d.push_back(CHAR_CR);
         crc = 16'hFFFF;
         foreach (d[k]) begin
            ch = d[k];
            for (int b = 0; b < 8; b++) begin
               fb = crc[0] ^ ch[0];
               crc = crc >> 1;
               if (fb) crc = crc ^ 16'h8408;
               ch = ch >> 1;
            end
         end
         crc = ~crc;
         line_q.push_back(hex_digit(crc[15:12]) ^ ((fault == FAULT_CHECK) ? 8'h01 : 8'h00));
         line_q.push_back(hex_digit(crc[11:8]));
         line_q.push_back(hex_digit(crc[7:4]));
         line_q.push_back(hex_digit(crc[3:0]));
         line_q.push_back(8'h2C);
         foreach (d[k]) line_q.push_back(d[k]);
      end
   endtask

   // A register write is only issued once the collector has drained: every
   // predicted beat popped, then a margin for blocks that yield no bytes.
   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SCRAMBLE_FIRST:  scr_a = val;
         CSR_SCRAMBLE_SECOND: scr_b = val;
         CSR_SCRAMBLE_THIRD:  scr_c = val;
         CSR_TYPE_MASK:       blk_mask = val;
         default:             blk_code = val;
      endcase
   endtask

   task automatic set_all(input logic [7:0] a, b, c, m, k);
      write_reg(CSR_SCRAMBLE_FIRST, a);
      write_reg(CSR_SCRAMBLE_SECOND, b);
      write_reg(CSR_SCRAMBLE_THIRD, c);
      write_reg(CSR_TYPE_MASK, m);
      write_reg(CSR_GPS_TYPE_CODE, k);
   endtask

   function automatic int pick_fault();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(FAULT_CHECK, FAULT_NOSTAR)
                                         : FAULT_NONE;
   endfunction

   // One random scenario: mostly whole lines with random content, the rest
   // noise beats, resyncs, stream clears and the odd overlong line.
   task automatic random_scenario();
      int pick;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0) send_item(ACT_RESYNC, 8'($urandom), 8'($urandom),
                                               8'($urandom));
      if (pick < 30) begin
         add_nmea(ST_POS, pick_fault(), $urandom_range(0, 30));
         flush_line();
         if ($urandom_range(0, 1) == 0) begin
            add_nmea(ST_TEXT, pick_fault(), $urandom_range(1, 25));
            flush_line();
         end
      end else if (pick < 48) begin
         add_nmea(ST_COURSE, pick_fault(), $urandom_range(0, 30));
         flush_line();
         if ($urandom_range(0, 2) == 0) begin
            add_nmea(ST_TEXT, FAULT_NONE, $urandom_range(1, 10));
            flush_line();
         end
      end else if (pick < 66) begin
         add_crc_packet(pick_fault(), $urandom_range(0, 25));
         flush_line();
      end else if (pick < 68) begin
         // Overlong line: no end character before the length limit.
         if ($urandom_range(0, 1) == 0) begin
            add_nmea(ST_POS, FAULT_NONE, MAX_LINE_LENGTH + 10);
            void'(line_q.pop_back());
         end else begin
            for (int i = 0; i < 5; i++) line_q.push_back(PFX_CRC_C[i]);
            repeat (MAX_LINE_LENGTH + 5) line_q.push_back(8'h41);
         end
         flush_line();
      end else if (pick < 72) begin
         send_item(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 6))
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic run_phase(input int target);
      int stop_at;
      stop_at = items_sent + target;
      while (items_sent < stop_at) random_scenario();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed start at reset settings: a short position sentence with a
      // text line after it, a CRC packet cut short, a resync, a clear, the
      // unused action and beats with all-zero and all-one bytes.
      add_nmea(ST_POS, FAULT_NONE, 0);
      flush_line();
      add_nmea(ST_TEXT, FAULT_NONE, 1);
      flush_line();
      add_crc_packet(FAULT_SHORT, 0);
      flush_line();
      send_item(ACT_DATA, 8'h00, 8'h00, 8'h00);
      send_item(ACT_RESYNC, 8'hFF, 8'hFF, 8'hFF);
      send_item(2'd3, 8'hFF, 8'hFF, 8'hFF);
      send_item(ACT_DATA, 8'hFF, 8'hFF, 8'hFF);
      send_item(ACT_DATA, 8'h00, 8'hFF, 8'h00);
      send_item(ACT_CLEAR, 8'h00, 8'h00, 8'h00);

      run_phase(90);
      // No scrambling and every block counts as GPS.
      set_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      run_phase(90);
      // Full scrambling and the type must match in every bit.
      set_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      run_phase(90);
      set_all(8'($urandom), 8'($urandom), 8'($urandom), 8'hF0, 8'h30);
      run_phase(90);
      // Last stretch without any stalls on either side.
      set_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 255)) & 8'hF0,
              8'h00);
      stalls_on = 1'b0;
      run_phase(70);

      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Sent %0d input beats in %0d lines over five register settings;",
               items_sent, lines_sent);
      $display("%0d stored-byte beats were checked against the model.", bytes_checked);
      if (errors == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== gps_slow_data_sentence_collector_unit.f =====
rtl/gsd_pkg.sv
rtl/gsd_front.sv
rtl/gsd_back.sv
rtl/gsd_rsp_queue.sv
rtl/gps_slow_data_sentence_collector_unit.sv
bench/gps_slow_data_sentence_collector_unit_checker.sv
bench/gps_slow_data_sentence_collector_unit_test.sv
